// File: rtl/decision_forest_vote_assert.svh
// ----------------------------------------------------------------------------
// decision_forest_vote assertion macros
// Concurrent checks on clk, disabled while arst_n is low. Define
// NO_ASSERTIONS to compile them away.
// ----------------------------------------------------------------------------
`ifndef DECISION_FOREST_VOTE_ASSERT_SVH
`define DECISION_FOREST_VOTE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check that cond holds at every edge.
`define DFV_CHECK(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("decision_forest_vote: check failed");

// Check that cons holds whenever ante holds.
`define DFV_CHECK_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("decision_forest_vote: implication failed");

`else

`define DFV_CHECK(label, cond)
`define DFV_CHECK_IMP(label, ante, cons)

`endif

`endif

// File: rtl/dfv_pkg.sv
// ----------------------------------------------------------------------------
// dfv_pkg
// Shared types and fixed field widths of the decision forest vote block.
// ----------------------------------------------------------------------------
package dfv_pkg;

	localparam int TSEL_W   = 4;
	localparam int NSEL_W   = 6;
	localparam int FEAT_W   = 3;
	localparam int VAL_W    = 31;
	localparam int VOTE_W   = 5;
	localparam int CNT_W    = 5;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	typedef struct packed {
		logic              is_leaf;
		logic              leaf_class;
		logic [FEAT_W-1:0] feature;
		logic [VAL_W-1:0]  threshold;
		logic [NSEL_W-1:0] left_child;
		logic [NSEL_W-1:0] right_child;
	} node_t;

	typedef enum logic {
		CMD_NODE_WR,
		CMD_SAMPLE
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [TSEL_W-1:0] tree_sel;
		logic [NSEL_W-1:0] node_sel;
		node_t             node;
		logic [FEAT_W-1:0] slot;
		logic              slot_ok;
		logic              last;
		logic [VAL_W-1:0]  value;
	} cmd_t;

	typedef enum logic [1:0] {
		W_IDLE,
		W_READ,
		W_EVAL,
		W_DONE
	} walk_state_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef struct packed {
		logic busy;
		logic result_load;
	} back_status_t;

endpackage

// File: rtl/dfv_front.sv
// ----------------------------------------------------------------------------
// dfv_front
// Accepts input beats, decodes the function and range-checks the indexes,
// then pushes a command into the queue. Writes that do nothing are dropped.
// ----------------------------------------------------------------------------
module dfv_front import dfv_pkg::*; #(
	parameter int MAX_TREES      = 16,
	parameter int NODES_PER_TREE = 64,
	parameter int NUM_FEATURES   = 8
) (
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              func,
	input  logic [TSEL_W-1:0] tree_sel,
	input  logic [NSEL_W-1:0] node_sel,
	input  logic              node_is_leaf,
	input  logic              node_leaf_class,
	input  logic [FEAT_W-1:0] node_feature,
	input  logic [VAL_W-1:0]  node_threshold,
	input  logic [NSEL_W-1:0] left_child,
	input  logic [NSEL_W-1:0] right_child,
	input  logic [FEAT_W-1:0] sample_slot,
	input  logic [VAL_W-1:0]  sample_value,
	input  logic              sample_last,
	input  q_status_t         q_stat,
	output logic              push,
	output cmd_t              cmd
);

	logic node_ok;
	logic slot_ok;
	logic keep;

	assign node_ok  = (32'(tree_sel) < MAX_TREES) && (32'(node_sel) < NODES_PER_TREE);
	assign slot_ok  = 32'(sample_slot) < NUM_FEATURES;
	// drop node writes out of range and samples that neither store nor trigger
	assign keep     = func ? (slot_ok || sample_last) : node_ok;
	assign in_ready = !q_stat.full;
	assign push     = in_valid && in_ready && keep;

	always_comb begin
		cmd.kind             = func ? CMD_SAMPLE : CMD_NODE_WR;
		cmd.tree_sel         = tree_sel;
		cmd.node_sel         = node_sel;
		cmd.node.is_leaf     = node_is_leaf;
		cmd.node.leaf_class  = node_leaf_class;
		cmd.node.feature     = node_feature;
		cmd.node.threshold   = node_threshold;
		cmd.node.left_child  = left_child;
		cmd.node.right_child = right_child;
		cmd.slot             = sample_slot;
		cmd.slot_ok          = slot_ok;
		cmd.last             = sample_last;
		cmd.value            = sample_value;
	end

endmodule

// File: rtl/dfv_queue.sv
// ----------------------------------------------------------------------------
// dfv_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module dfv_queue import dfv_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  cmd_t      push_cmd,
	input  logic      pop,
	output cmd_t      head_cmd,
	output q_status_t q_stat
);

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign q_stat.full  = count_q == QCNT_W'(QUEUE_DEPTH);
	assign q_stat.empty = count_q == '0;
	assign do_push      = push && !q_stat.full;
	assign do_pop       = pop && !q_stat.empty;
	assign head_cmd     = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (do_pop)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= push_cmd;
	end

endmodule

// File: rtl/dfv_walk.sv
// ----------------------------------------------------------------------------
// dfv_walk
// Back end: holds the node table and feature store, executes queued
// commands and walks every tree in use, then holds the vote result.
// ----------------------------------------------------------------------------
module dfv_walk import dfv_pkg::*; #(
	parameter int MAX_TREES      = 16,
	parameter int NODES_PER_TREE = 64,
	parameter int MAX_DEPTH      = 5,
	parameter int NUM_FEATURES   = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CNT_W-1:0] tree_count,
	input  cmd_t             cmd,
	input  q_status_t        q_stat,
	output logic             pop,
	input  logic             out_ready,
	output logic             out_valid,
	output logic             is_match,
	output logic [VOTE_W-1:0] vote_total,
	output back_status_t     status
);

	localparam int NODE_DEPTH = MAX_TREES * NODES_PER_TREE;
	localparam int NA_W       = (NODE_DEPTH > 1) ? $clog2(NODE_DEPTH) : 1;
	localparam int TREE_W     = $clog2(MAX_TREES + 1);
	localparam int DEPTH_W    = $clog2(MAX_DEPTH + 1);
	localparam int FIDX_W     = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;

	node_t             node_mem [NODE_DEPTH];
	node_t             node_rd_q;
	logic [VAL_W-1:0]  feat_mem [NUM_FEATURES];

	walk_state_t       state_q, state_d;
	logic [TREE_W-1:0] tree_q;
	logic [TREE_W-1:0] ntree_q;
	logic [TREE_W-1:0] votes_q;
	logic [NA_W-1:0]   base_q;
	logic [NSEL_W-1:0] cur_q;
	logic [DEPTH_W-1:0] depth_q;
	logic              res_valid_q;
	logic              res_match_q;
	logic [VOTE_W-1:0] res_votes_q;

	logic              start;
	logic [TREE_W-1:0] ntree_eff;
	logic              mem_we;
	logic              feat_we;
	logic              rd_en;
	logic              res_load;
	logic              out_free;
	logic [NA_W-1:0]   wr_addr;
	logic [NA_W-1:0]   rd_addr;
	logic              feat_ok;
	logic [VAL_W-1:0]  feat_val;
	logic [NSEL_W-1:0] nxt;
	logic              stop;
	logic              last_tree;

	assign ntree_eff = (32'(tree_count) > MAX_TREES) ? TREE_W'(MAX_TREES)
	                                                 : TREE_W'(tree_count);
	assign out_free  = !res_valid_q || out_ready;
	assign start     = pop && (cmd.kind == CMD_SAMPLE) && cmd.last;

	assign wr_addr = NA_W'(NA_W'(cmd.tree_sel) * NA_W'(NODES_PER_TREE)) + NA_W'(cmd.node_sel);
	assign rd_addr = base_q + NA_W'(cur_q);

	// one step of the walk on the node read last cycle
	assign feat_ok   = 32'(node_rd_q.feature) < NUM_FEATURES;
	assign feat_val  = feat_ok ? feat_mem[FIDX_W'(node_rd_q.feature)] : '0;
	assign nxt       = (feat_val < node_rd_q.threshold) ? node_rd_q.left_child
	                                                    : node_rd_q.right_child;
	assign stop      = node_rd_q.is_leaf || (depth_q == DEPTH_W'(MAX_DEPTH))
	                   || (32'(nxt) >= NODES_PER_TREE);
	assign last_tree = (tree_q + TREE_W'(1)) == ntree_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			W_IDLE: begin
				if (start) state_d = (ntree_eff == '0) ? W_DONE : W_READ;
			end
			W_READ: state_d = W_EVAL;
			W_EVAL: begin
				if (!stop) state_d = W_READ;
				else       state_d = last_tree ? W_DONE : W_READ;
			end
			W_DONE: begin
				if (out_free) state_d = W_IDLE;
			end
			default: state_d = W_IDLE;
		endcase
	end

	always_comb begin
		pop      = (state_q == W_IDLE) && !q_stat.empty;
		mem_we   = pop && (cmd.kind == CMD_NODE_WR);
		feat_we  = pop && (cmd.kind == CMD_SAMPLE) && cmd.slot_ok;
		rd_en    = state_q == W_READ;
		res_load = (state_q == W_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= W_IDLE;
			tree_q      <= '0;
			ntree_q     <= '0;
			votes_q     <= '0;
			base_q      <= '0;
			cur_q       <= '0;
			depth_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start) begin
				tree_q  <= '0;
				ntree_q <= ntree_eff;
				votes_q <= '0;
				base_q  <= '0;
				cur_q   <= '0;
				depth_q <= '0;
			end else if (state_q == W_EVAL) begin
				if (!stop) begin
					cur_q   <= nxt;
					depth_q <= depth_q + DEPTH_W'(1);
				end else begin
					votes_q <= votes_q + TREE_W'(node_rd_q.leaf_class);
					tree_q  <= tree_q + TREE_W'(1);
					base_q  <= base_q + NA_W'(NODES_PER_TREE);
					cur_q   <= '0;
					depth_q <= '0;
				end
			end
			if (res_load)               res_valid_q <= 1'b1;
			else if (out_ready)         res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_match_q <= votes_q > (ntree_q >> 1);
			res_votes_q <= VOTE_W'(votes_q);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) node_mem[wr_addr] <= cmd.node;
		if (rd_en)  node_rd_q <= node_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (feat_we) feat_mem[FIDX_W'(cmd.slot)] <= cmd.value;
	end

	assign out_valid          = res_valid_q;
	assign is_match           = res_match_q;
	assign vote_total         = res_votes_q;
	assign status.busy        = state_q != W_IDLE;
	assign status.result_load = res_load;

endmodule

// File: rtl/decision_forest_vote.sv
// ----------------------------------------------------------------------------
// decision_forest_vote
// Forest of binary decision trees with a majority vote. Node-write beats
// (func 0) load one entry of the node table; sample beats (func 1) load one
// feature slot, and a sample beat with sample_last set walks trees
// 0..tree_count-1 from their roots (tree_count saturates at MAX_TREES). At an
// inner node the walk goes left when the feature is below the threshold and
// right otherwise; it stops at a leaf, at a child index beyond the tree, or
// after MAX_DEPTH steps, and the reached node's class is the tree's vote. One
// result beat follows: vote_total and is_match (votes above half the tree
// count). Node writes and samples that do not trigger a walk are executed
// by the back end and produce no result; input beats are taken into a
// two-entry queue, so a fresh beat is accepted every cycle while the back end
// keeps up. A triggering sample walks every tree in use, each tree needing
// 1 to MAX_DEPTH + 1 node reads, because every step reads the single-port
// node table and evaluates the registered node in the following cycle. The
// walk hands its result to an output register and returns to queued beats
// while that result waits.
// tree_count is set through cfg_wr_en / cfg_wr_data, reset value 1; write it
// only while the block is idle. The node table and feature slots have no
// reset and must be written before a walk reads them.
// ----------------------------------------------------------------------------
`include "decision_forest_vote_assert.svh"

module decision_forest_vote import dfv_pkg::*; #(
	parameter int MAX_TREES      = 16,
	parameter int NODES_PER_TREE = 64,
	parameter int MAX_DEPTH      = 5,
	parameter int NUM_FEATURES   = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [CNT_W-1:0]  cfg_wr_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              func,
	input  logic [TSEL_W-1:0] tree_sel,
	input  logic [NSEL_W-1:0] node_sel,
	input  logic              node_is_leaf,
	input  logic              node_leaf_class,
	input  logic [FEAT_W-1:0] node_feature,
	input  logic [VAL_W-1:0]  node_threshold,
	input  logic [NSEL_W-1:0] left_child,
	input  logic [NSEL_W-1:0] right_child,
	input  logic [FEAT_W-1:0] sample_slot,
	input  logic [VAL_W-1:0]  sample_value,
	input  logic              sample_last,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              is_match,
	output logic [VOTE_W-1:0] vote_total
);

	// tree count register, written directly, no read-back
	logic [CNT_W-1:0] tree_count_q;

	// front to queue
	logic         q_push;
	cmd_t         q_push_cmd;
	// queue to back
	logic         q_pop;
	cmd_t         q_head_cmd;
	q_status_t    q_stat;
	back_status_t back_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tree_count_q <= CNT_W'(1);
		end else if (cfg_wr_en) begin
			tree_count_q <= cfg_wr_data;
		end
	end

	// Decode and range-check each beat; drop node writes outside the table.
	dfv_front #(
		.MAX_TREES      (MAX_TREES),
		.NODES_PER_TREE (NODES_PER_TREE),
		.NUM_FEATURES   (NUM_FEATURES)
	) u_front (
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.func            (func),
		.tree_sel        (tree_sel),
		.node_sel        (node_sel),
		.node_is_leaf    (node_is_leaf),
		.node_leaf_class (node_leaf_class),
		.node_feature    (node_feature),
		.node_threshold  (node_threshold),
		.left_child      (left_child),
		.right_child     (right_child),
		.sample_slot     (sample_slot),
		.sample_value    (sample_value),
		.sample_last     (sample_last),
		.q_stat          (q_stat),
		.push            (q_push),
		.cmd             (q_push_cmd)
	);

	// Hold commands while the back end walks the forest.
	dfv_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_push_cmd),
		.pop      (q_pop),
		.head_cmd (q_head_cmd),
		.q_stat   (q_stat)
	);

	// Execute commands in order: table writes, feature writes and walks.
	dfv_walk #(
		.MAX_TREES      (MAX_TREES),
		.NODES_PER_TREE (NODES_PER_TREE),
		.MAX_DEPTH      (MAX_DEPTH),
		.NUM_FEATURES   (NUM_FEATURES)
	) u_walk (
		.clk        (clk),
		.arst_n     (arst_n),
		.tree_count (tree_count_q),
		.cmd        (q_head_cmd),
		.q_stat     (q_stat),
		.pop        (q_pop),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.is_match   (is_match),
		.vote_total (vote_total),
		.status     (back_stat)
	);

	// The queue can never claim to be full and empty at once.
	`DFV_CHECK(a_queue_state_sane, !(q_stat.full && q_stat.empty))
	// No command leaves the queue while a walk or its result hand-off runs.
	`DFV_CHECK_IMP(a_no_pop_while_busy, back_stat.busy, !q_pop)
	// A new result only appears right after the back end loaded it.
	`DFV_CHECK_IMP(a_result_from_walk, $rose(out_valid), $past(back_stat.result_load))

endmodule

// File: test/decision_forest_vote_tb.sv
// ----------------------------------------------------------------------------
// decision_forest_vote testbench
// Builds small random forests through node-write beats, fills the feature
// slots with sample beats and closes each sample run with a last sample that
// triggers a vote. A scoreboard class keeps its own copy of the node table,
// the feature slots and tree_count, walks every tree in use for each
// triggering beat and checks each result beat field by field. Both
// handshakes idle at random, and tree_count is swept across several values,
// the saturating ones included.
// ----------------------------------------------------------------------------
module decision_forest_vote_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dfv_pkg::*;

	// Block geometry, kept equal to the defaults of the block.
	localparam int TREES       = 16;
	localparam int NODES       = 64;
	localparam int WALK_DEPTH  = 5;
	localparam int FEATS       = 8;

	localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

	// This pause covers any work still in flight once the results are in.
	localparam int SETTLE      = 250;
	localparam int CYCLE_LIMIT = 800_000;
	localparam int PHASE_BEATS = 135;
	localparam int PHASES      = 7;
	localparam int PRINT_CAP   = 50;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [TSEL_W-1:0] tree_sel;
		logic [NSEL_W-1:0] node_sel;
		node_t             node;
		logic [FEAT_W-1:0] slot;
		logic [VAL_W-1:0]  value;
		logic              last;
	} forest_beat_t;

	typedef struct packed {
		logic              hit;
		logic [VOTE_W-1:0] total;
	} vote_t;

	// Scoreboard: mirrors the node table, the feature slots and tree_count,
	// and predicts the vote for every triggering sample beat.
	class vote_board;
		node_t             forest [TREES][NODES];
		logic [VAL_W-1:0]  features [FEATS];
		logic [CNT_W-1:0]  tree_count;
		vote_t             pending_votes [$];
		int                errors;
		int                checked;
		int                hits;

		function new();
			tree_count = CNT_W'(1);
			errors     = 0;
			checked    = 0;
			hits       = 0;
		endfunction

		function void set_tree_count(logic [CNT_W-1:0] n);
			tree_count = n;
		endfunction

		// Walk each tree in use from its root; stop at a leaf or after the
		// depth limit and take the class bit of the node reached.
		function vote_t count_votes();
			int                trees;
			int                step;
			logic [NSEL_W-1:0] cur;
			logic [VAL_W-1:0]  fv;
			vote_t             v;
			node_t             nd;
			trees   = (tree_count > TREES) ? TREES : int'(tree_count);
			v.total = '0;
			for (int t = 0; t < trees; t++) begin
				cur = '0;
				for (step = 0; step < WALK_DEPTH && !forest[t][cur].is_leaf; step++) begin
					nd  = forest[t][cur];
					fv  = features[nd.feature];
					cur = (fv < nd.threshold) ? nd.left_child : nd.right_child;
				end
				v.total = v.total + VOTE_W'(forest[t][cur].leaf_class);
			end
			v.hit = (int'(v.total) > trees / 2);
			return v;
		endfunction

		function void note_beat(forest_beat_t b);
			if (b.kind == CMD_NODE_WR) begin
				forest[b.tree_sel][b.node_sel] = b.node;
			end else begin
				features[b.slot] = b.value;
				if (b.last)
					pending_votes.insert(pending_votes.size(), count_votes());
			end
		endfunction

		task report(string what);
			errors++;
			// Cap the log; every mismatch still counts.
			if (errors <= PRINT_CAP)
				$display("mismatch at %0t ns: %s", $time, what);
		endtask

		task check_vote(logic hit, logic [VOTE_W-1:0] total);
			vote_t want;
			if (pending_votes.size() == 0) begin
				report($sformatf("result with nothing pending: is_match %0d vote_total %0d",
					hit, total));
			end else begin
				want = pending_votes.pop_front();
				checked++;
				if (want.hit)
					hits++;
				if (hit !== want.hit)
					report($sformatf("is_match %0d, want %0d", hit, want.hit));
				if (total !== want.total)
					report($sformatf("vote_total %0d, want %0d", total, want.total));
			end
		endtask
	endclass

	// Block inputs, all known from time zero.
	logic              clk             = 1'b0;
	logic              arst_n          = 1'b0;
	logic              cfg_wr_en       = 1'b0;
	logic [CNT_W-1:0]  cfg_wr_data     = '0;
	logic              in_valid        = 1'b0;
	logic              func            = 1'b0;
	logic [TSEL_W-1:0] tree_sel        = '0;
	logic [NSEL_W-1:0] node_sel        = '0;
	logic              node_is_leaf    = 1'b0;
	logic              node_leaf_class = 1'b0;
	logic [FEAT_W-1:0] node_feature    = '0;
	logic [VAL_W-1:0]  node_threshold  = '0;
	logic [NSEL_W-1:0] left_child      = '0;
	logic [NSEL_W-1:0] right_child     = '0;
	logic [FEAT_W-1:0] sample_slot     = '0;
	logic [VAL_W-1:0]  sample_value    = '0;
	logic              sample_last     = 1'b0;
	logic              out_ready       = 1'b0;

	// Block outputs.
	logic              in_ready;
	logic              out_valid;
	logic              is_match;
	logic [VOTE_W-1:0] vote_total;

	vote_board         board;

	// Stimulus-side shadow: which nodes each tree has had written, and the
	// last value sent to each feature slot. A new inner node only points at
	// nodes already written, so no walk ever reads an unwritten entry.
	logic [NODES-1:0]  built [TREES];
	logic [VAL_W-1:0]  feat_shadow [FEATS];

	int                beats_sent = 0;
	int                cycles     = 0;
	logic              steady     = 1'b0;   // no idling on either side
	logic [CNT_W-1:0]  plan [PHASES];

	decision_forest_vote dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.func            (func),
		.tree_sel        (tree_sel),
		.node_sel        (node_sel),
		.node_is_leaf    (node_is_leaf),
		.node_leaf_class (node_leaf_class),
		.node_feature    (node_feature),
		.node_threshold  (node_threshold),
		.left_child      (left_child),
		.right_child     (right_child),
		.sample_slot     (sample_slot),
		.sample_value    (sample_value),
		.sample_last     (sample_last),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.is_match        (is_match),
		.vote_total      (vote_total)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Watchdog: end the run if it drags far past any correct length.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d votes still pending",
				cycles, board.pending_votes.size());
			$display("FAIL decision_forest_vote");
			$finish;
		end
	end

	// Result side: stall at random about 16 percent of the time unless running steady.
	always @(posedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= steady || ($urandom_range(0, 99) >= 16);
	end

	// Check every result beat; the values read here are the ones from
	// before the edge, so the order of processes does not matter.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_vote(is_match, vote_total);
	end

	// Offer one beat, with random idle cycles ahead of it, and hold it until
	// the block takes it. Returns at the edge of acceptance.
	task automatic send_beat(input forest_beat_t b);
		while (!steady && $urandom_range(0, 99) < 16) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid        <= 1'b1;
		func            <= b.kind;
		tree_sel        <= b.tree_sel;
		node_sel        <= b.node_sel;
		node_is_leaf    <= b.node.is_leaf;
		node_leaf_class <= b.node.leaf_class;
		node_feature    <= b.node.feature;
		node_threshold  <= b.node.threshold;
		left_child      <= b.node.left_child;
		right_child     <= b.node.right_child;
		sample_slot     <= b.slot;
		sample_value    <= b.value;
		sample_last     <= b.last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		board.note_beat(b);
		beats_sent++;
	endtask

	// Node write; the sample fields ride along with random content.
	task automatic send_node(input int t, input int n, input node_t nd);
		forest_beat_t b;
		b.kind     = CMD_NODE_WR;
		b.tree_sel = TSEL_W'(t);
		b.node_sel = NSEL_W'(n);
		b.node     = nd;
		b.slot     = FEAT_W'($urandom);
		b.value    = VAL_W'($urandom);
		b.last     = 1'($urandom);
		built[t][n] = 1'b1;
		send_beat(b);
	endtask

	// Feature sample; the node fields ride along with random content.
	task automatic send_sample(input int slot, input logic [VAL_W-1:0] value,
		input logic last);
		forest_beat_t b;
		b.kind     = CMD_SAMPLE;
		b.tree_sel = TSEL_W'($urandom);
		b.node_sel = NSEL_W'($urandom);
		b.node     = node_t'(48'({$urandom, $urandom}));
		b.slot     = FEAT_W'(slot);
		b.value    = value;
		b.last     = last;
		feat_shadow[slot] = value;
		send_beat(b);
	endtask

	function automatic logic [VAL_W-1:0] feature_value();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return VAL_MAX;
			2: return VAL_W'(1);
			default: return VAL_W'($urandom);
		endcase
	endfunction

	// Random node entry. Most land on low indices so trees grow dense and
	// walks run deep; children are drawn from nodes already written (or the
	// node itself), which also makes loops that run into the depth limit.
	task automatic send_random_node();
		int     t;
		int     n;
		int     members [$];
		node_t  nd;
		logic [NODES-1:0] reach;
		t = $urandom_range(0, TREES - 1);
		n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, NODES - 1) : $urandom_range(0, 11);
		reach    = built[t];
		reach[n] = 1'b1;
		for (int i = 0; i < NODES; i++)
			if (reach[i])
				members.insert(members.size(), i);
		nd.is_leaf    = ($urandom_range(0, 99) < 35);
		nd.leaf_class = 1'($urandom);
		nd.feature    = FEAT_W'($urandom);
		case ($urandom_range(0, 7))
			0: nd.threshold = '0;
			1: nd.threshold = VAL_MAX;
			2: nd.threshold = feat_shadow[nd.feature];             // equal: go right
			3: nd.threshold = feat_shadow[nd.feature] + 1'b1;      // just above: go left
			default: nd.threshold = VAL_W'($urandom);
		endcase
		if (nd.is_leaf) begin
			// Children of a leaf are never followed.
			nd.left_child  = NSEL_W'($urandom);
			nd.right_child = NSEL_W'($urandom);
		end else begin
			nd.left_child  = NSEL_W'(members[$urandom_range(0, members.size() - 1)]);
			nd.right_child = NSEL_W'(members[$urandom_range(0, members.size() - 1)]);
		end
		send_node(t, n, nd);
	endtask

	// Drop valid, wait out every pending vote, then let trailing node
	// writes and samples clear the back end.
	task automatic quiesce();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.pending_votes.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_tree_count(input logic [CNT_W-1:0] n);
		quiesce();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= n;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		board.set_tree_count(n);
	endtask

	// Random traffic: mostly well-formed runs (a few node writes, a few
	// samples, then a last sample), the rest loose node writes and samples
	// that never close.
	task automatic run_phase(input int beats);
		int stop_at;
		stop_at = beats_sent + beats;
		while (beats_sent < stop_at) begin
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 3)) send_random_node();
				if ($urandom_range(0, 1) == 0)
					send_sample($urandom_range(0, FEATS - 1), feature_value(), 1'b0);
			end else begin
				repeat ($urandom_range(0, 4)) send_random_node();
				repeat ($urandom_range(0, 3))
					send_sample($urandom_range(0, FEATS - 1), feature_value(), 1'b0);
				send_sample($urandom_range(0, FEATS - 1), feature_value(), 1'b1);
			end
		end
	endtask

	initial begin
		board = new();
		for (int t = 0; t < TREES; t++)
			built[t] = '0;
		for (int s = 0; s < FEATS; s++)
			feat_shadow[s] = '0;

		// Tree counts to sweep: full forest, none, both saturating values,
		// one tree, a random middle value, and a mid count.
		plan[0] = CNT_W'(16);
		plan[1] = CNT_W'(0);
		plan[2] = CNT_W'(31);
		plan[3] = CNT_W'(17);
		plan[4] = CNT_W'(1);
		plan[5] = CNT_W'($urandom_range(2, 15));
		plan[6] = CNT_W'(9);

		// Hold reset, then release it on an edge.
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: fill every feature slot with extreme and middle values.
		send_sample(0, '0, 1'b0);
		send_sample(1, VAL_MAX, 1'b0);
		send_sample(2, VAL_W'(1), 1'b0);
		send_sample(3, VAL_MAX - 1'b1, 1'b0);
		send_sample(4, VAL_W'(32'h4000_0000), 1'b0);
		send_sample(5, VAL_W'(32'h3FFF_FFFF), 1'b0);
		send_sample(6, VAL_W'($urandom), 1'b0);
		send_sample(7, VAL_W'($urandom), 1'b0);

		// Directed: a root for every tree. Tree 0 compares the max feature
		// against the max threshold, goes right to itself and ends on the
		// depth limit at an inner node of class 1. Odd trees are leaves;
		// even trees loop on themselves with threshold zero or max.
		send_node(0, 0, '{is_leaf: 1'b0, leaf_class: 1'b1, feature: FEAT_W'(1),
			threshold: VAL_MAX, left_child: '0, right_child: '0});
		for (int t = 1; t < TREES; t++) begin
			if (t % 2 == 1)
				send_node(t, 0, '{is_leaf: 1'b1, leaf_class: 1'(t >> 1), feature: FEAT_W'(t),
					threshold: VAL_W'($urandom), left_child: '0, right_child: '0});
			else
				send_node(t, 0, '{is_leaf: 1'b0, leaf_class: 1'(t >> 2), feature: FEAT_W'(t),
					threshold: (t % 4 == 0) ? '0 : VAL_MAX, left_child: '0, right_child: '0});
		end

		// Vote with the reset tree count of one.
		send_sample(7, VAL_MAX, 1'b1);

		// Tree 0: feature 0 below threshold 1 goes left to a class-0 leaf;
		// then feature 0 equal to the threshold goes right to the root loop.
		send_node(0, 1, '{is_leaf: 1'b1, leaf_class: 1'b0, feature: '0,
			threshold: '0, left_child: '0, right_child: '0});
		send_node(0, 0, '{is_leaf: 1'b0, leaf_class: 1'b1, feature: '0,
			threshold: VAL_W'(1), left_child: NSEL_W'(1), right_child: '0});
		send_sample(0, '0, 1'b1);
		send_sample(0, VAL_W'(1), 1'b1);

		// Random phases, one tree count each; the third runs without idling.
		for (int p = 0; p < PHASES; p++) begin
			write_tree_count(plan[p]);
			steady = (p == 2);
			run_phase(PHASE_BEATS);
			steady = 1'b0;
		end

		quiesce();

		$display("covered %0d input beats over %0d tree-count settings (0, 1, 16, 17, 31 among them)",
			beats_sent, PHASES + 1);
		$display("checked %0d votes, %0d of them matches, %0d mismatches",
			board.checked, board.hits, board.errors);
		if (board.errors == 0 && board.pending_votes.size() == 0)
			$display("PASS decision_forest_vote");
		else
			$display("FAIL decision_forest_vote");
		$finish;
	end

endmodule
